// ===== rtl/pme_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pme_pkg : shared types and constants of the pixel message embedder
// Sizes of the message store and the pixel index, request kinds, and the
// structs passed between the control stage, the memory and the datapath.
// ----------------------------------------------------------------------------
package pme_pkg;

   // Message store and index sizes
   localparam int MAX_CHARS  = 1024;
   localparam int INDEX_BITS = 24;
   localparam int CODE_W     = 6;
   localparam int ADDR_W     = $clog2(MAX_CHARS);
   localparam int LEN_W      = $clog2(MAX_CHARS + 1);
   localparam int HD_W       = 24;
   localparam int CHAN_W     = 8;

   // Character codes with fixed meaning
   localparam logic [CODE_W-1:0] CODE_NONE    = CODE_W'(0);
   localparam logic [CODE_W-1:0] CODE_SPACE   = CODE_W'(1);
   localparam logic [CODE_W-1:0] CODE_NEWLINE = CODE_W'(38);

   // CSR word index of hide_distance
   localparam logic REG_HIDE_DISTANCE = 1'b0;

   // Request kinds on the input channel
   typedef enum logic [1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_APPEND = 2'd1,
      REQ_PIXEL  = 2'd2
   } req_kind_type;

   // Pixel handed from the control stage to the datapath
   typedef struct packed {
      logic              hit;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pix_type;

   // Memory command from the control stage
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CODE_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_cmd_type;

endpackage
`default_nettype wire

// ===== rtl/pixel_message_embedder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_message_embedder_core : hides a text message in an RGB pixel stream
// Characters load into a message store as codes; carrier pixels spaced by
// hide_distance take one code each, spread over blue, green and red.
//
//   Channel   Handshake             Beat content
//   req       req_valid/req_ready   req_type, character, pixel, start mark
//   rsp       rsp_valid/rsp_ready   channels out, embedded flag, code used
//   csr       psel/penable/pready   hide_distance at word 0
//
// One request beat per cycle while req_ready is high; a pixel's result is
// held in the store-read stage during the message store read, then in the
// result register. Clear, append and unused request beats give no result.
// Reset clears the control counters and sets hide_distance to one; the
// message store is not cleared, only entries written since are read.
// A stalled result holds in the output register and the pixel behind it in
// the store-read stage; req_ready drops only while both are full.
// ----------------------------------------------------------------------------
module pixel_message_embedder_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [1:0]                     req_type,
   input  wire logic [7:0]                     req_character,
   input  wire logic [pme_pkg::CHAN_W-1:0]     req_blue_in,
   input  wire logic [pme_pkg::CHAN_W-1:0]     req_green_in,
   input  wire logic [pme_pkg::CHAN_W-1:0]     req_red_in,
   input  wire logic                           req_start_of_image,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [pme_pkg::CHAN_W-1:0]     rsp_blue_out,
   output logic      [pme_pkg::CHAN_W-1:0]     rsp_green_out,
   output logic      [pme_pkg::CHAN_W-1:0]     rsp_red_out,
   output logic                                rsp_embedded,
   output logic      [pme_pkg::CODE_W-1:0]     rsp_code_used,
   // configuration port
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [2:0]                     paddr,
   input  wire logic [31:0]                    pwdata,
   output logic      [31:0]                    prdata,
   output logic                                pready
);

   localparam int HW = pme_pkg::HD_W;

   logic [HW-1:0]        hd_ff, hd_in;
   logic                 accept;
   logic                 csr_wr;
   logic                 pix_valid;
   logic                 pix_ready;
   pme_pkg::pix_type     pix;
   pme_pkg::mem_cmd_type mem_cmd;
   logic [pme_pkg::CODE_W-1:0] rd_code;

   assign pready    = 1'b1;
   assign req_ready = pix_ready;
   assign accept    = req_valid && req_ready;

   // Register write and read back
   assign csr_wr = psel && penable && pwrite && pready;
   always_comb begin
      hd_in = hd_ff;
      if (csr_wr && paddr[2] == pme_pkg::REG_HIDE_DISTANCE) begin
         hd_in = pwdata[HW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hd_ff <= HW'(1);
      end else begin
         hd_ff <= hd_in;
      end
   end

   assign prdata = (paddr[2] == pme_pkg::REG_HIDE_DISTANCE) ? 32'(hd_ff) : 32'd0;

   pme_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .req_type           (req_type),
      .req_character      (req_character),
      .req_blue_in        (req_blue_in),
      .req_green_in       (req_green_in),
      .req_red_in         (req_red_in),
      .req_start_of_image (req_start_of_image),
      .hide_distance      (hd_ff),
      .pix_valid          (pix_valid),
      .pix                (pix),
      .mem_cmd            (mem_cmd)
   );

   pme_ram #(
      .WIDTH (pme_pkg::CODE_W),
      .DEPTH (pme_pkg::MAX_CHARS)
   ) u_msg_ram (
      .clock   (clock),
      .wr_en   (mem_cmd.wr_en),
      .wr_addr (mem_cmd.wr_addr),
      .wr_data (mem_cmd.wr_data),
      .rd_en   (mem_cmd.rd_en),
      .rd_addr (mem_cmd.rd_addr),
      .rd_data (rd_code)
   );

   pme_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .pix_valid     (pix_valid),
      .pix           (pix),
      .rd_code       (rd_code),
      .pix_ready     (pix_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_green_out (rsp_green_out),
      .rsp_red_out   (rsp_red_out),
      .rsp_embedded  (rsp_embedded),
      .rsp_code_used (rsp_code_used)
   );

endmodule
`default_nettype wire

// ===== rtl/pme_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pme_ram : generic single-write, single-read synchronous RAM
// Read data is registered and holds until the next read.
// ----------------------------------------------------------------------------
module pme_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/pme_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pme_ctrl : request decode and embedding control
// Maps appended characters to codes and writes them to the message store,
// tracks pixel index, next carrier pixel and codes placed, and issues the
// message store read for each carrier pixel.
// ----------------------------------------------------------------------------
module pme_ctrl (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                accept,
   input  wire logic [1:0]                          req_type,
   input  wire logic [7:0]                          req_character,
   input  wire logic [pme_pkg::CHAN_W-1:0]          req_blue_in,
   input  wire logic [pme_pkg::CHAN_W-1:0]          req_green_in,
   input  wire logic [pme_pkg::CHAN_W-1:0]          req_red_in,
   input  wire logic                                req_start_of_image,
   input  wire logic [pme_pkg::HD_W-1:0]            hide_distance,
   output logic                                     pix_valid,
   output pme_pkg::pix_type                         pix,
   output pme_pkg::mem_cmd_type                     mem_cmd
);

   localparam int IW = pme_pkg::INDEX_BITS;
   localparam int LW = pme_pkg::LEN_W;
   localparam int AW = pme_pkg::ADDR_W;
   localparam int CW = pme_pkg::CODE_W;
   localparam logic [LW-1:0] MAX_LEN = LW'(pme_pkg::MAX_CHARS);

   // ASCII landmarks
   localparam logic [7:0] ASCII_NL    = 8'd10;
   localparam logic [7:0] ASCII_SPACE = 8'd32;
   localparam logic [7:0] ASCII_0     = 8'd48;
   localparam logic [7:0] ASCII_9     = 8'd57;
   localparam logic [7:0] ASCII_UA    = 8'd65;
   localparam logic [7:0] ASCII_UZ    = 8'd90;
   localparam logic [7:0] ASCII_LA    = 8'd97;
   localparam logic [7:0] ASCII_LZ    = 8'd122;
   localparam logic [7:0] OFS_UPPER   = 8'd63;
   localparam logic [7:0] OFS_LOWER   = 8'd95;
   localparam logic [7:0] OFS_DIGIT   = 8'd20;

   function automatic logic [CW-1:0] char_to_code(input logic [7:0] ch);
      logic [7:0] t;
      t = 8'd0;
      if (ch == ASCII_SPACE) begin
         t = 8'(pme_pkg::CODE_SPACE);
      end else if (ch >= ASCII_UA && ch <= ASCII_UZ) begin
         t = ch - OFS_UPPER;
      end else if (ch >= ASCII_LA && ch <= ASCII_LZ) begin
         t = ch - OFS_LOWER;
      end else if (ch >= ASCII_0 && ch <= ASCII_9) begin
         t = ch - OFS_DIGIT;
      end else if (ch == ASCII_NL) begin
         t = 8'(pme_pkg::CODE_NEWLINE);
      end
      return t[CW-1:0];
   endfunction

   logic [LW-1:0] length_ff, length_in;
   logic [LW-1:0] chars_ff,  chars_in;
   logic [IW-1:0] index_ff,  index_in;
   logic [IW-1:0] target_ff, target_in;

   logic [IW-1:0] hd_idx;
   logic [IW-1:0] cur_index;
   logic [IW-1:0] cur_target;
   logic [LW-1:0] cur_chars;
   logic [CW-1:0] app_code;
   logic          app_ok;
   logic          hit;
   logic          is_pixel;

   assign hd_idx   = IW'(hide_distance);
   assign app_code = char_to_code(req_character);
   assign app_ok   = (app_code != pme_pkg::CODE_NONE) && (length_ff < MAX_LEN);
   assign is_pixel = (req_type == pme_pkg::REQ_PIXEL);

   // Start mark restarts the image before the pixel is judged
   assign cur_index  = req_start_of_image ? '0 : index_ff;
   assign cur_chars  = req_start_of_image ? '0 : chars_ff;
   assign cur_target = req_start_of_image ? hd_idx : target_ff;
   assign hit        = (cur_target != '0) && (cur_index == cur_target) &&
                       (cur_chars < length_ff);

   // Next state of the control registers
   always_comb begin
      length_in = length_ff;
      chars_in  = chars_ff;
      index_in  = index_ff;
      target_in = target_ff;
      if (accept) begin
         case (pme_pkg::req_kind_type'(req_type))
            pme_pkg::REQ_CLEAR: begin
               length_in = '0;
               chars_in  = '0;
               target_in = '0;
            end
            pme_pkg::REQ_APPEND: begin
               if (app_ok) begin
                  length_in = length_ff + LW'(1);
               end
            end
            pme_pkg::REQ_PIXEL: begin
               chars_in  = hit ? cur_chars + LW'(1) : cur_chars;
               target_in = hit ? cur_target + hd_idx : cur_target;
               index_in  = cur_index + IW'(1);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         chars_ff  <= '0;
         index_ff  <= '0;
         target_ff <= '0;
      end else begin
         length_ff <= length_in;
         chars_ff  <= chars_in;
         index_ff  <= index_in;
         target_ff <= target_in;
      end
   end

   // Drive the message store: append writes, carrier pixels read
   always_comb begin
      mem_cmd.wr_en   = accept && (req_type == pme_pkg::REQ_APPEND) && app_ok;
      mem_cmd.wr_addr = length_ff[AW-1:0];
      mem_cmd.wr_data = app_code;
      mem_cmd.rd_en   = accept && is_pixel && hit;
      mem_cmd.rd_addr = cur_chars[AW-1:0];
   end

   // Hand the pixel to the datapath
   assign pix_valid = accept && is_pixel;
   always_comb begin
      pix.hit   = hit;
      pix.blue  = req_blue_in;
      pix.green = req_green_in;
      pix.red   = req_red_in;
   end

   a_chars_le_length: assert property (@(posedge clock) disable iff (reset)
      chars_ff <= length_ff)
      else $error("codes placed exceed message length");

   a_length_le_max: assert property (@(posedge clock) disable iff (reset)
      length_ff <= MAX_LEN)
      else $error("message length beyond store depth");

   a_no_rd_wr_same_beat: assert property (@(posedge clock) disable iff (reset)
      !(mem_cmd.rd_en && mem_cmd.wr_en))
      else $error("message store read and write in one beat");

   a_hit_advances: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.rd_en |=> chars_ff == $past(cur_chars) + LW'(1))
      else $error("carrier pixel did not advance code count");

endmodule
`default_nettype wire

// ===== rtl/pme_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pme_dpath : pixel datapath and result register
// Holds the pixel while the message store read completes, applies the code
// to the three channels and keeps the result until the consumer takes it.
// ----------------------------------------------------------------------------
module pme_dpath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           pix_valid,
   input  wire pme_pkg::pix_type               pix,
   input  wire logic [pme_pkg::CODE_W-1:0]     rd_code,
   output logic                                pix_ready,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [pme_pkg::CHAN_W-1:0]     rsp_blue_out,
   output logic      [pme_pkg::CHAN_W-1:0]     rsp_green_out,
   output logic      [pme_pkg::CHAN_W-1:0]     rsp_red_out,
   output logic                                rsp_embedded,
   output logic      [pme_pkg::CODE_W-1:0]     rsp_code_used
);

   localparam int CW = pme_pkg::CODE_W;
   localparam int HW = pme_pkg::CHAN_W;

   // Add when the channel has headroom, else subtract
   function automatic logic [HW-1:0] shift_channel(input logic [HW-1:0] v,
                                                   input logic [CW-1:0] amt);
      logic [HW:0] lim;
      lim = (HW+1)'(255) - (HW+1)'(amt);
      if ((HW+1)'(v) < lim) begin
         return v + HW'(amt);
      end
      return v - HW'(amt);
   endfunction

   logic             s2_valid_ff, s2_valid_in;
   pme_pkg::pix_type s2_pix_ff;
   logic             out_valid_ff, out_valid_in;
   logic [HW-1:0]    blue_ff, green_ff, red_ff;
   logic             emb_ff;
   logic [CW-1:0]    code_ff;

   logic          out_free;
   logic          s2_free;
   logic [CW-1:0] code;
   logic [12:0]   prod;
   logic [CW-1:0] quot;
   logic [CW-1:0] rem;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign s2_free   = !s2_valid_ff || out_free;
   assign pix_ready = s2_free;

   // Split the code: quotient by three through reciprocal 43/128
   assign code = s2_pix_ff.hit ? rd_code : pme_pkg::CODE_NONE;
   assign prod = 13'(code) * 13'd43;
   assign quot = CW'(prod >> 7);
   assign rem  = code - CW'(quot * CW'(3));

   // Advance the pipeline slots
   always_comb begin
      s2_valid_in  = s2_free ? pix_valid : s2_valid_ff;
      out_valid_in = out_free ? s2_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the pixel and the finished result
   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_pix_ff <= pix;
      end
      if (out_free) begin
         blue_ff  <= shift_channel(s2_pix_ff.blue, quot);
         green_ff <= shift_channel(s2_pix_ff.green, quot);
         red_ff   <= shift_channel(s2_pix_ff.red, quot + rem);
         emb_ff   <= s2_pix_ff.hit;
         code_ff  <= code;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_green_out = green_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_embedded  = emb_ff;
   assign rsp_code_used = code_ff;

   a_embedded_has_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_embedded) |-> rsp_code_used != pme_pkg::CODE_NONE)
      else $error("embedded pixel without code");

   a_plain_has_no_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_embedded) |-> rsp_code_used == pme_pkg::CODE_NONE)
      else $error("plain pixel reports a code");

endmodule
`default_nettype wire

// ===== tb/pixel_message_embedder_core_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_message_embedder_core_checker : predicts and checks embedded pixels
// Watches the request, result and register ports of the embedder. Keeps its
// own copy of the message store, counters and hide distance, works out the
// pixel that each pixel beat must give, and compares every result beat with
// the oldest pixel still due.
// ----------------------------------------------------------------------------
module pixel_message_embedder_core_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire logic [1:0]                     req_type,
   input  wire logic [7:0]                     req_character,
   input  wire logic [pme_pkg::CHAN_W-1:0]     req_blue_in,
   input  wire logic [pme_pkg::CHAN_W-1:0]     req_green_in,
   input  wire logic [pme_pkg::CHAN_W-1:0]     req_red_in,
   input  wire logic                           req_start_of_image,
   // result channel
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire logic [pme_pkg::CHAN_W-1:0]     rsp_blue_out,
   input  wire logic [pme_pkg::CHAN_W-1:0]     rsp_green_out,
   input  wire logic [pme_pkg::CHAN_W-1:0]     rsp_red_out,
   input  wire logic                           rsp_embedded,
   input  wire logic [pme_pkg::CODE_W-1:0]     rsp_code_used,
   // register port
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [2:0]                     paddr,
   input  wire logic [31:0]                    pwdata,
   input  wire logic                           pready,
   // status to the testbench top
   output int                                  failures,
   output int                                  pending,
   output int                                  pixels_checked,
   output int                                  carriers_checked
);

   typedef struct packed {
      logic [pme_pkg::CHAN_W-1:0] blue;
      logic [pme_pkg::CHAN_W-1:0] green;
      logic [pme_pkg::CHAN_W-1:0] red;
      logic                       embedded;
      logic [pme_pkg::CODE_W-1:0] code;
   } pixel_out_type;

   // Shadow of the embedder state
   logic [pme_pkg::CODE_W-1:0]     stored_code [pme_pkg::MAX_CHARS];
   int unsigned                    msg_len;
   int unsigned                    placed;
   logic [pme_pkg::INDEX_BITS-1:0] pix_idx;
   logic [pme_pkg::INDEX_BITS-1:0] target;
   logic [pme_pkg::HD_W-1:0]       spacing;
   pixel_out_type                  pixels_due [$];

   // Map an ASCII byte to its message code; unknown bytes map to none
   function automatic logic [pme_pkg::CODE_W-1:0] code_of_char(input logic [7:0] ch);
      if (ch == " ") return pme_pkg::CODE_SPACE;
      if (ch >= "A" && ch <= "Z") return pme_pkg::CODE_W'(ch - 8'd63);
      if (ch >= "a" && ch <= "z") return pme_pkg::CODE_W'(ch - 8'd95);
      if (ch >= "0" && ch <= "9") return pme_pkg::CODE_W'(ch - 8'd20);
      if (ch == 8'd10) return pme_pkg::CODE_NEWLINE;
      return pme_pkg::CODE_NONE;
   endfunction

   // Add the amount unless that would reach the top of the range
   function automatic logic [pme_pkg::CHAN_W-1:0] nudge_channel(
         input logic [pme_pkg::CHAN_W-1:0] v,
         input logic [pme_pkg::CODE_W-1:0] amt);
      if (int'(v) < 255 - int'(amt)) return pme_pkg::CHAN_W'(int'(v) + int'(amt));
      return pme_pkg::CHAN_W'(int'(v) - int'(amt));
   endfunction

   // Advance the image counters for one pixel and queue the pixel it must give
   task automatic embed_pixel();
      pixel_out_type              px;
      logic [pme_pkg::CODE_W-1:0] q;
      logic [pme_pkg::CODE_W-1:0] rem;
      px.blue     = req_blue_in;
      px.green    = req_green_in;
      px.red      = req_red_in;
      px.embedded = 1'b0;
      px.code     = pme_pkg::CODE_NONE;
      if (req_start_of_image) begin
         pix_idx = '0;
         placed  = 0;
         target  = spacing[pme_pkg::INDEX_BITS-1:0];
      end
      if (target != '0 && pix_idx == target && placed < msg_len &&
          placed < pme_pkg::MAX_CHARS) begin
         px.code     = stored_code[placed];
         q           = pme_pkg::CODE_W'(px.code / 3);
         rem         = pme_pkg::CODE_W'(px.code % 3);
         px.blue     = nudge_channel(px.blue, q);
         px.green    = nudge_channel(px.green, q);
         px.red      = nudge_channel(px.red, q + rem);
         px.embedded = 1'b1;
         placed++;
         target = target + spacing[pme_pkg::INDEX_BITS-1:0];
      end
      pix_idx = pix_idx + 1'b1;
      pixels_due.insert(pixels_due.size(), px);
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch
      pixel_out_type              want;
      logic [pme_pkg::CODE_W-1:0] code;
      if (reset) begin
         msg_len  = 0;
         placed   = 0;
         pix_idx  = '0;
         target   = '0;
         spacing  = pme_pkg::HD_W'(1);
         pixels_due.delete();
      end else begin
         // check the result beat against the oldest pixel due
         if (rsp_valid && rsp_ready) begin
            if (pixels_due.size() == 0) begin
               $error("result beat with no pixel due: blue_out %0d green_out %0d red_out %0d",
                      rsp_blue_out, rsp_green_out, rsp_red_out);
               failures++;
            end else begin
               want = pixels_due.pop_front();
               compare_field("blue_out", int'(want.blue), int'(rsp_blue_out));
               compare_field("green_out", int'(want.green), int'(rsp_green_out));
               compare_field("red_out", int'(want.red), int'(rsp_red_out));
               compare_field("embedded", int'(want.embedded), int'(rsp_embedded));
               compare_field("code_used", int'(want.code), int'(rsp_code_used));
               pixels_checked++;
               if (want.embedded) carriers_checked++;
            end
         end
         // request beat, judged with the distance held before this edge
         if (req_valid && req_ready) begin
            case (req_type)
               pme_pkg::REQ_CLEAR: begin
                  msg_len = 0;
                  placed  = 0;
                  target  = '0;
               end
               pme_pkg::REQ_APPEND: begin
                  code = code_of_char(req_character);
                  if (code != pme_pkg::CODE_NONE && msg_len < pme_pkg::MAX_CHARS) begin
                     stored_code[msg_len] = code;
                     msg_len++;
                  end
               end
               pme_pkg::REQ_PIXEL: embed_pixel();
               default: ;
            endcase
         end
         // register write
         if (psel && penable && pwrite && pready &&
             paddr == {pme_pkg::REG_HIDE_DISTANCE, 2'b00}) begin
            spacing = pwdata[pme_pkg::HD_W-1:0];
         end
      end
      pending = pixels_due.size();
   end

endmodule
`default_nettype wire

// ===== tb/pixel_message_embedder_core_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_message_embedder_core_tb : stimulus and verdict for the embedder
// Loads messages, streams images through the embedder under several sender
// and receiver idle patterns and hide distances, and leaves all checking of
// the result beats to the checker placed beside the embedder.
// ----------------------------------------------------------------------------
module pixel_message_embedder_core_tb;

   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam int         ITEM_TARGET  = 1400;
   localparam int         MIN_PHASES   = 4;
   localparam int         LIMIT_CYCLES = 600000;
   localparam int         DRAIN_CYCLES = 8;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_type = pme_pkg::REQ_CLEAR;
   logic [7:0]                    req_character = '0;
   logic [pme_pkg::CHAN_W-1:0]    req_blue_in = '0;
   logic [pme_pkg::CHAN_W-1:0]    req_green_in = '0;
   logic [pme_pkg::CHAN_W-1:0]    req_red_in = '0;
   logic                          req_start_of_image = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [pme_pkg::CHAN_W-1:0]    rsp_blue_out;
   logic [pme_pkg::CHAN_W-1:0]    rsp_green_out;
   logic [pme_pkg::CHAN_W-1:0]    rsp_red_out;
   logic                          rsp_embedded;
   logic [pme_pkg::CODE_W-1:0]    rsp_code_used;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [2:0]                    paddr = '0;
   logic [31:0]                   pwdata = '0;
   logic [31:0]                   prdata;
   logic                          pready;

   int failures;
   int pending;
   int pixels_checked;
   int carriers_checked;
   int beats_sent = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_off_len = 0;

   // Directed pixels, blue/green/red, chosen around the add/subtract threshold
   logic [23:0] directed_pix [8] = '{24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'hF6F5F6,
                                     24'hF5F6F5, 24'hF3F2F2, 24'hF2F3F1, 24'h804007};
   logic [7:0]  directed_text [11] = '{" ", "A", "z", "0", "9", 8'd10, "@", "{",
                                       8'hFF, "a", "Z"};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   pixel_message_embedder_core DUT (
      .clock, .reset,
      .req_valid, .req_ready, .req_type, .req_character,
      .req_blue_in, .req_green_in, .req_red_in, .req_start_of_image,
      .rsp_valid, .rsp_ready, .rsp_blue_out, .rsp_green_out, .rsp_red_out,
      .rsp_embedded, .rsp_code_used,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   pixel_message_embedder_core_checker checker_i (
      .clock, .reset,
      .req_valid, .req_ready, .req_type, .req_character,
      .req_blue_in, .req_green_in, .req_red_in, .req_start_of_image,
      .rsp_valid, .rsp_ready, .rsp_blue_out, .rsp_green_out, .rsp_red_out,
      .rsp_embedded, .rsp_code_used,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .failures, .pending, .pixels_checked, .carriers_checked
   );

   // Receiver: stall at random, or hold off for a counted stretch on request
   initial begin : receiver
      forever begin
         @(negedge clock);
         if (hold_off_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_len) @(negedge clock);
            hold_off_len = 0;
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog
   initial begin : watchdog
      #(LIMIT_CYCLES * 12);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int draw_gap(input int pct);
      int n;
      n = 0;
      while (n < 24 && $urandom_range(99) < pct) n++;
      return n;
   endfunction

   function automatic logic [pme_pkg::CHAN_W-1:0] random_channel();
      case ($urandom_range(7))
         0:       return 8'd0;
         1:       return 8'd255;
         2, 3:    return 8'($urandom_range(236, 255));
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly message characters; with noise allowed, some arbitrary bytes
   function automatic logic [7:0] pick_char(input bit noise_ok);
      case ($urandom_range(noise_ok ? 9 : 8))
         0:       return " ";
         1:       return 8'd10;
         2, 3:    return 8'($urandom_range(65, 90));
         4, 5:    return 8'($urandom_range(97, 122));
         6, 7:    return 8'($urandom_range(48, 57));
         8:       return noise_ok ? 8'($urandom_range(32, 126)) : "Q";
         default: return 8'($urandom);
      endcase
   endfunction

   // Offer one beat from a falling edge; return at the falling edge after it is taken
   task automatic send_beat(input logic [1:0] kind, input logic [7:0] ch,
                            input logic [pme_pkg::CHAN_W-1:0] b,
                            input logic [pme_pkg::CHAN_W-1:0] g,
                            input logic [pme_pkg::CHAN_W-1:0] r, input logic sof);
      int gap;
      gap = draw_gap(send_idle_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_character      <= ch;
      req_blue_in        <= b;
      req_green_in       <= g;
      req_red_in         <= r;
      req_start_of_image <= sof;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic send_pixel(input logic sof);
      send_beat(pme_pkg::REQ_PIXEL, 8'($urandom), random_channel(), random_channel(),
                random_channel(), sof);
   endtask

   task automatic send_char(input logic [7:0] ch);
      send_beat(pme_pkg::REQ_APPEND, ch, 8'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom));
   endtask

   task automatic send_control(input logic [1:0] kind);
      send_beat(kind, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom));
   endtask

   // Drop valid, wait for every pixel to come back and for the pipe to empty
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (4) @(negedge clock);
   endtask

   // Register write: setup cycle, then access cycle
   task automatic write_spacing(input logic [pme_pkg::HD_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {pme_pkg::REG_HIDE_DISTANCE, 2'b00};
      pwdata  <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_idle(input int phase_no);
      case (phase_no % 4)
         0:       begin send_idle_pct = 0;  stall_pct = 0;  end
         1:       begin send_idle_pct = 79; stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  stall_pct = 79; end
         default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
   endtask

   // One message and one image; mostly well formed, with some noise beats
   task automatic run_phase(input int phase_no);
      int                          spacing;
      int                          msg_len;
      int                          n_pix;
      logic [pme_pkg::HD_W-1:0]    second;
      settle();
      set_idle(phase_no);
      spacing = ($urandom_range(5) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      write_spacing(pme_pkg::HD_W'(spacing));
      msg_len = $urandom_range(1, 14);
      send_control(pme_pkg::REQ_CLEAR);
      repeat (msg_len) send_char(pick_char(1'b1));
      n_pix = spacing * (msg_len + 1) + $urandom_range(0, 4);
      if (n_pix > 90) n_pix = 90;
      // in a no-idle phase, hold the receiver off so the pipe fills and stalls
      if (phase_no % 4 == 0) hold_off_len = $urandom_range(60, 100);
      for (int i = 0; i < n_pix; i++) begin
         case ($urandom_range(39))
            0:       send_control(REQ_UNUSED);
            1:       send_char(pick_char(1'b1));
            2:       send_pixel(1'b1);
            3:       if ($urandom_range(3) == 0) send_control(pme_pkg::REQ_CLEAR);
                     else send_pixel(1'b0);
            default: send_pixel(i == 0);
         endcase
      end
      // change the distance mid-image and carry on without a start mark
      if (phase_no % 3 == 2) begin
         settle();
         second = pme_pkg::HD_W'($urandom_range(1, 5));
         write_spacing(second);
         repeat (20) send_pixel(1'b0);
      end
   endtask

   initial begin : stimulus
      int phase_no;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: pixels before any start mark, then codes of every class
      send_pixel(1'b0);
      send_pixel(1'b0);
      foreach (directed_text[i]) send_char(directed_text[i]);
      send_control(REQ_UNUSED);
      foreach (directed_pix[i]) begin
         send_beat(pme_pkg::REQ_PIXEL, 8'h00, directed_pix[i][23:16], directed_pix[i][15:8],
                   directed_pix[i][7:0], i == 0);
      end
      send_control(pme_pkg::REQ_CLEAR);
      send_pixel(1'b0);

      // distance of zero, then the largest distance: nothing gets embedded
      settle();
      write_spacing('0);
      repeat (5) send_char(pick_char(1'b0));
      send_pixel(1'b1);
      repeat (10) send_pixel(1'b0);
      settle();
      write_spacing('1);
      send_pixel(1'b1);
      repeat (10) send_pixel(1'b0);

      // fill the message store past its size, then read back the first codes
      settle();
      set_idle(3);
      write_spacing(pme_pkg::HD_W'(1));
      send_control(pme_pkg::REQ_CLEAR);
      repeat (pme_pkg::MAX_CHARS + 6) send_char(pick_char(1'b0));
      send_pixel(1'b1);
      repeat (40) send_pixel(1'b0);

      // random phases, rotating through every idle pattern at least once
      phase_no = 0;
      while (beats_sent < ITEM_TARGET || phase_no < MIN_PHASES) begin
         run_phase(phase_no);
         phase_no++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Summary: %0d request beats in %0d phases, %0d pixels checked, %0d with a code.",
               beats_sent, phase_no, pixels_checked, carriers_checked);
      $display("Summary: hide distances 0, 1, max and random; message store filled past size.");
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/pme_pkg.sv
rtl/pme_ram.sv
rtl/pme_ctrl.sv
rtl/pme_dpath.sv
rtl/pixel_message_embedder_core.sv
tb/pixel_message_embedder_core_checker.sv
tb/pixel_message_embedder_core_tb.sv
